### src/ggpd_pkg.sv
`timescale 1ns / 1ps

package ggpd_pkg;

    localparam int PROD_W = 26;
    localparam int THR_W  = 30;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam int ON_THR_PER_TAP = 393000;
    localparam int SAT_HI         = 536870911;
    localparam int SAT_LO         = -536870912;

    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [THR_W-1:0]  t_thr;

    typedef enum logic {
        REG_ON_THR  = 1'b0,
        REG_OFF_THR = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic  vld;
        t_prod prod;
        t_prod old;
    } t_ring_rd;

endpackage

### src/ggpd_regs.sv
`timescale 1ns / 1ps

module ggpd_regs #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ggpd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ggpd_pkg::DATA_W-1:0]    pwdata,
    output logic [ggpd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output ggpd_pkg::t_thr                 o_on_thr,
    output ggpd_pkg::t_thr                 o_off_thr
);

    localparam int TW = ggpd_pkg::THR_W;
    localparam int DW = ggpd_pkg::DATA_W;
    localparam ggpd_pkg::t_thr ON_RST = TW'(ggpd_pkg::ON_THR_PER_TAP * WINDOW_LEN);

    ggpd_pkg::t_thr     r_on_thr;
    ggpd_pkg::t_thr     r_off_thr;
    ggpd_pkg::t_reg_idx idx;
    logic               wr;

    assign idx    = ggpd_pkg::t_reg_idx'(paddr[2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_thr  <= ON_RST;
            r_off_thr <= '0;
        end else if (wr) begin
            unique case (idx)
                ggpd_pkg::REG_ON_THR:  r_on_thr  <= pwdata[TW-1:0];
                ggpd_pkg::REG_OFF_THR: r_off_thr <= pwdata[TW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            ggpd_pkg::REG_ON_THR:  prdata = DW'(r_on_thr);
            ggpd_pkg::REG_OFF_THR: prdata = DW'(r_off_thr);
            default:               prdata = '0;
        endcase
    end

    assign o_on_thr  = r_on_thr;
    assign o_off_thr = r_off_thr;

endmodule

### src/ggpd_ring.sv
`timescale 1ns / 1ps

module ggpd_ring #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_gyro_sample,
    input  logic        [9:0]   i_elapsed_ms,
    input  logic                i_take,
    output ggpd_pkg::t_ring_rd  o_rd
);

    localparam int PW = $clog2(WINDOW_LEN);
    localparam int PRW = ggpd_pkg::PROD_W;

    ggpd_pkg::t_prod         mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]   r_filled;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           n_pos;
    logic                    r_s1_vld;
    ggpd_pkg::t_prod         r_prod;
    ggpd_pkg::t_prod         r_old_raw;
    logic                    r_old_hit;
    logic                    accept;
    logic signed [PRW:0]     prod_full;
    ggpd_pkg::t_prod         prod;

    assign accept     = i_in_valid && (!r_s1_vld || i_take);
    assign o_in_stall = r_s1_vld && !i_take;

    assign prod_full = i_gyro_sample * $signed({1'b0, i_elapsed_ms});
    assign prod      = prod_full[PRW-1:0];
    assign n_pos     = (r_pos == PW'(WINDOW_LEN - 1)) ? '0 : r_pos + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_pos    <= '0;
            r_filled <= '0;
        end else begin
            if (accept) begin
                r_s1_vld        <= 1'b1;
                r_pos           <= n_pos;
                r_filled[r_pos] <= 1'b1;
            end else if (i_take) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // Read-first: the registered read returns the product from one window ago.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_pos] <= prod;
            r_old_raw  <= mem[r_pos];
            r_old_hit  <= r_filled[r_pos];
            r_prod     <= prod;
        end
    end

    assign o_rd.vld  = r_s1_vld;
    assign o_rd.prod = r_prod;
    assign o_rd.old  = r_old_hit ? r_old_raw : '0;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(WINDOW_LEN - 1))
        else $error("ring position beyond window");

    a_stage_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted sample lost before the sum stage");
`endif

endmodule

### src/ggpd_detect.sv
`timescale 1ns / 1ps

module ggpd_detect #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ggpd_pkg::t_ring_rd  i_rd,
    output logic                o_take,
    input  ggpd_pkg::t_thr      i_on_thr,
    input  ggpd_pkg::t_thr      i_off_thr,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_fire_on,
    output logic                o_fire_off,
    output ggpd_pkg::t_thr      o_window_sum
);

    localparam int EXACT_W = $clog2(WINDOW_LEN) + ggpd_pkg::PROD_W + 1;
    localparam int SW      = (EXACT_W > 31) ? EXACT_W : 31;
    localparam int TW      = ggpd_pkg::THR_W;
    localparam logic signed [SW-1:0] SAT_HI = SW'(ggpd_pkg::SAT_HI);
    localparam logic signed [SW-1:0] SAT_LO = SW'(ggpd_pkg::SAT_LO);

    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    ggpd_pkg::t_thr       r_prev;
    ggpd_pkg::t_thr       sum_sat;
    logic                 r_rise;
    logic                 r_fall;
    logic                 r_out_valid;
    logic                 r_fire_on;
    logic                 r_fire_off;
    ggpd_pkg::t_thr       r_window_sum;
    logic                 on;
    logic                 off;
    logic                 rise_mid;
    logic                 fall_mid;

    assign o_take = i_rd.vld && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_sum = r_sum + SW'(i_rd.prod) - SW'(i_rd.old);
        if (n_sum > SAT_HI) begin
            sum_sat = SAT_HI[TW-1:0];
        end else if (n_sum < SAT_LO) begin
            sum_sat = SAT_LO[TW-1:0];
        end else begin
            sum_sat = n_sum[TW-1:0];
        end
        on       = (sum_sat > i_on_thr) && (sum_sat > r_prev) && r_rise;
        rise_mid = on ? 1'b0 : r_rise;
        fall_mid = on ? 1'b1 : r_fall;
        off      = (sum_sat < i_off_thr) && (sum_sat < r_prev) && fall_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_prev      <= '0;
            r_rise      <= 1'b1;
            r_fall      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_sum       <= n_sum;
                r_prev      <= sum_sat;
                r_rise      <= off ? 1'b1 : rise_mid;
                r_fall      <= off ? 1'b0 : fall_mid;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_fire_on    <= on;
            r_fire_off   <= off;
            r_window_sum <= sum_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_fire_on    = r_fire_on;
    assign o_fire_off   = r_fire_off;
    assign o_window_sum = r_window_sum;

`ifndef SYNTHESIS
    a_one_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rise || r_fall)
        else $error("both events disarmed");

    a_on_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fire_on && !r_fire_off) |-> (!r_rise && r_fall))
        else $error("rising event did not swap the arm flags");

    a_off_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_fire_off) |-> (r_rise && !r_fall))
        else $error("falling event did not swap the arm flags");
`endif

endmodule

### src/gyro_gait_phase_detector_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_gyro_sample, i_elapsed_ms
// output    out        o_out_valid / i_out_stall o_fire_on, o_fire_off, o_window_sum
// config    in         psel / penable / pready   paddr, pwdata, prdata
//
// One sample per cycle unless stalled; the ring and sum stages each register it.
// The product ring sits in one memory that is read and written at the ring position
// in the same cycle, so the rate is set by that single memory port.
// Active-low synchronous reset: ring valid bits, sums cleared; both arm flags set.
// A stalled output still lets one more transaction into the ring stage.

module gyro_gait_phase_detector_core #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [15:0]            i_gyro_sample,
    input  logic        [9:0]             i_elapsed_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_fire_on,
    output logic                          o_fire_off,
    output logic signed [29:0]            o_window_sum,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ggpd_pkg::ADDR_W-1:0]   paddr,
    input  logic [ggpd_pkg::DATA_W-1:0]   pwdata,
    output logic [ggpd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    ggpd_pkg::t_thr     on_thr;
    ggpd_pkg::t_thr     off_thr;
    ggpd_pkg::t_ring_rd rd;
    logic               take;

    ggpd_regs #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_on_thr (on_thr),
        .o_off_thr(off_thr)
    );

    ggpd_ring #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_gyro_sample(i_gyro_sample),
        .i_elapsed_ms (i_elapsed_ms),
        .i_take       (take),
        .o_rd         (rd)
    );

    ggpd_detect #(
        .WINDOW_LEN(WINDOW_LEN)
    ) u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (rd),
        .o_take      (take),
        .i_on_thr    (on_thr),
        .i_off_thr   (off_thr),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_fire_on   (o_fire_on),
        .o_fire_off  (o_fire_off),
        .o_window_sum(o_window_sum)
    );

endmodule
